[hw/rtl/sbp_pkg.sv]
// Shared types, field widths and codes for the splitter bucket partitioner.
package sbp_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned SIDX_W      = 6;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned BUCKET_W    = 7;
  localparam int unsigned SLOT_W      = 16;
  localparam int unsigned ADDR_W      = 22;
  localparam int unsigned PARTS_CFG_W = 7;
  localparam int unsigned CAP_CFG_W   = 17;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_IDX_W   = 1;

  // Input tdata: splitter_index, element_value, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned S_TUSER_W = KIND_W;
  // Output tdata: bucket_index, slot, buffer_address, element_value_res.
  localparam int unsigned M_TDATA_W = 112;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [PARTS_CFG_W-1:0] PARTS_RESET = 7'd64;
  localparam logic [CAP_CFG_W-1:0]   CAP_RESET   = 17'd65536;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD     = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_CLEAR    = 2'd2
  } sbp_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PARTS    = 1'b0,
    CFG_BUCKET_CAPACITY = 1'b1
  } sbp_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CNT_RD,
    ST_UPDATE
  } sbp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic classify;
    logic clear;
    logic step;
    logic cnt_rd;
    logic commit;
  } sbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_last;
    logic parts_zero;
    logic out_free;
  } sbp_sts_t;

endpackage

[hw/rtl/sbp_ctrl.sv]
// Controller state machine: sequences load, clear, search and count update.
module sbp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic [sbp_pkg::KIND_W-1:0]    kind_i,
  output logic                          s_ready_o,
  input  sbp_pkg::sbp_sts_t             sts_i,
  output sbp_pkg::sbp_cmd_t             cmd_o
);

  sbp_pkg::sbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbp_pkg::ST_IDLE: begin
        if (s_valid_i && (kind_i == sbp_pkg::KIND_CLASSIFY)) begin
          state_d = sts_i.parts_zero ? sbp_pkg::ST_CNT_RD : sbp_pkg::ST_SEARCH;
        end
      end
      sbp_pkg::ST_SEARCH: begin
        if (sts_i.search_last) begin
          state_d = sbp_pkg::ST_CNT_RD;
        end
      end
      sbp_pkg::ST_CNT_RD: begin
        state_d = sbp_pkg::ST_UPDATE;
      end
      sbp_pkg::ST_UPDATE: begin
        if (sts_i.out_free) begin
          state_d = sbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      sbp_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          unique case (kind_i)
            sbp_pkg::KIND_LOAD:     cmd_o.load     = 1'b1;
            sbp_pkg::KIND_CLASSIFY: cmd_o.classify = 1'b1;
            sbp_pkg::KIND_CLEAR:    cmd_o.clear    = 1'b1;
            default: ;
          endcase
        end
      end
      sbp_pkg::ST_SEARCH: begin
        cmd_o.step = 1'b1;
      end
      sbp_pkg::ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
      end
      sbp_pkg::ST_UPDATE: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/sbp_datapath.sv]
// Datapath: splitter memory, search registers, bucket counters and result register.
module sbp_datapath #(
  parameter int unsigned NUM_PARTS    = 64,
  parameter int unsigned MAX_CAPACITY = 65536,
  localparam int unsigned PW   = $clog2(NUM_PARTS + 1),
  localparam int unsigned IW   = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1,
  localparam int unsigned CAPW = $clog2(MAX_CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbp_pkg::sbp_cmd_t              cmd_i,
  output sbp_pkg::sbp_sts_t              sts_o,
  input  logic [PW-1:0]                  parts_i,
  input  logic [CAPW-1:0]                cap_i,
  input  logic [sbp_pkg::SIDX_W-1:0]     sidx_i,
  input  logic [sbp_pkg::VALUE_W-1:0]    value_i,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic [sbp_pkg::BUCKET_W-1:0]   bucket_o,
  output logic [sbp_pkg::SLOT_W-1:0]     slot_o,
  output logic [sbp_pkg::ADDR_W-1:0]     addr_o,
  output logic [sbp_pkg::VALUE_W-1:0]    value_o,
  output logic                           beyond_o,
  output logic                           full_o
);

  localparam int unsigned PRODW = PW + CAPW;

  // Splitter table, reset undefined.
  logic [sbp_pkg::VALUE_W-1:0] spl_mem [NUM_PARTS];
  logic [sbp_pkg::VALUE_W-1:0] spl_rd_q;
  logic [IW-1:0]               spl_rd_addr;
  logic                        spl_wr_en;

  // Bucket counters with a valid bit per entry; an invalid entry reads as zero.
  logic [CAPW-1:0]      cnt_mem [NUM_PARTS];
  logic [NUM_PARTS-1:0] cnt_vld_q;
  logic [CAPW-1:0]      cnt_rd_q;
  logic                 cnt_vld_rd_q;
  logic [IW-1:0]        cnt_addr;

  logic [sbp_pkg::VALUE_W-1:0] elem_q;
  logic [PW-1:0]    lo_q, lo_d, hi_q, hi_d, found_q, found_d, mid_q, mid_d;
  logic [PW-1:0]    lo_n, hi_n, found_n;
  logic             gt;
  logic [PRODW-1:0] prod_q;

  logic [CAPW-1:0]  count;
  logic             beyond, full, ok;
  logic [PRODW-1:0] addr_full;

  logic                         m_valid_q;
  logic [sbp_pkg::BUCKET_W-1:0] bucket_q;
  logic [sbp_pkg::SLOT_W-1:0]   slot_q;
  logic [sbp_pkg::ADDR_W-1:0]   addr_q;
  logic [sbp_pkg::VALUE_W-1:0]  value_q;
  logic                         beyond_q, full_q;

  // One search step: signed compare against the probed splitter.
  assign gt      = $signed(spl_rd_q) > $signed(elem_q);
  assign found_n = gt ? mid_q : found_q;
  assign hi_n    = gt ? mid_q : hi_q;
  assign lo_n    = gt ? lo_q : (mid_q + 1'b1);

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    found_d = found_q;
    mid_d   = mid_q;
    if (cmd_i.classify) begin
      lo_d    = '0;
      hi_d    = parts_i;
      found_d = parts_i;
      mid_d   = (parts_i - 1'b1) >> 1;
    end else if (cmd_i.step) begin
      lo_d    = lo_n;
      hi_d    = hi_n;
      found_d = found_n;
      mid_d   = lo_n + ((hi_n - 1'b1 - lo_n) >> 1);
    end
  end

  // The upper bound is kept exclusive, so the range is empty when lo reaches hi.
  assign sts_o.search_last = !(lo_n < hi_n);
  assign sts_o.parts_zero  = (parts_i == '0);
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

  assign spl_rd_addr = mid_d[IW-1:0];
  assign spl_wr_en   = cmd_i.load && (32'(sidx_i) < NUM_PARTS);

  always_ff @(posedge clk_i) begin
    if (spl_wr_en) begin
      spl_mem[IW'(sidx_i)] <= value_i;
    end
    spl_rd_q <= spl_mem[spl_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      elem_q <= value_i;
    end
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    mid_q   <= mid_d;
  end

  assign cnt_addr = found_q[IW-1:0];

  // Count lookup and the address product are registered in the same cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) begin
      cnt_rd_q     <= cnt_mem[cnt_addr];
      cnt_vld_rd_q <= cnt_vld_q[cnt_addr];
      prod_q       <= PRODW'(found_q) * PRODW'(cap_i);
    end
  end

  assign count     = cnt_vld_rd_q ? cnt_rd_q : '0;
  assign beyond    = (found_q >= parts_i);
  assign full      = !beyond && (count >= cap_i);
  assign ok        = !beyond && !full;
  assign addr_full = prod_q + PRODW'(count);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok) begin
      cnt_mem[cnt_addr] <= count + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.commit && ok) begin
      cnt_vld_q[cnt_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      bucket_q <= sbp_pkg::BUCKET_W'(found_q);
      slot_q   <= ok ? sbp_pkg::SLOT_W'(count) : '0;
      addr_q   <= ok ? sbp_pkg::ADDR_W'(addr_full) : '0;
      value_q  <= elem_q;
      beyond_q <= beyond;
      full_q   <= full;
    end
  end

  assign m_valid_o = m_valid_q;
  assign bucket_o  = bucket_q;
  assign slot_o    = slot_q;
  assign addr_o    = addr_q;
  assign value_o   = value_q;
  assign beyond_o  = beyond_q;
  assign full_o    = full_q;

endmodule

[hw/rtl/splitter_bucket_partitioner.sv]
// Classify transaction: accepted in the idle state, then search steps that probe the splitter
// memory (none when no parts are active), a count lookup and an update that writes the result.
// The result sits in an output register and the next transaction is accepted while it waits.
// Load and clear transactions give no result.
// Reset (asynchronous, active low) clears all bucket counts; the splitter table is undefined.
module splitter_bucket_partitioner #(
  parameter int unsigned NUM_PARTS    = 64,
  parameter int unsigned MAX_CAPACITY = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // splitter_index [5:0], element_value [69:6], zero padding [71:70]
  input  logic [sbp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // kind [1:0]
  input  logic [sbp_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // bucket_index [6:0], slot [22:7], buffer_address [44:23],
  // element_value_res [108:45], zero padding [111:109]
  output logic [sbp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // beyond_all [0], bucket_full [1]
  output logic [sbp_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PW   = $clog2(NUM_PARTS + 1);
  localparam int unsigned CAPW = $clog2(MAX_CAPACITY + 1);

  logic [sbp_pkg::PARTS_CFG_W-1:0] active_parts_q;
  logic [sbp_pkg::CAP_CFG_W-1:0]   bucket_capacity_q;
  logic [PW-1:0]                   parts_eff;
  logic [CAPW-1:0]                 cap_eff;

  sbp_pkg::sbp_cmd_t cmd;
  sbp_pkg::sbp_sts_t sts;

  logic [sbp_pkg::BUCKET_W-1:0] res_bucket;
  logic [sbp_pkg::SLOT_W-1:0]   res_slot;
  logic [sbp_pkg::ADDR_W-1:0]   res_addr;
  logic [sbp_pkg::VALUE_W-1:0]  res_value;
  logic                         res_beyond, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_parts_q    <= sbp_pkg::PARTS_RESET;
      bucket_capacity_q <= sbp_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sbp_pkg::CFG_ACTIVE_PARTS:
          active_parts_q <= cfg_data_i[sbp_pkg::PARTS_CFG_W-1:0];
        sbp_pkg::CFG_BUCKET_CAPACITY:
          bucket_capacity_q <= cfg_data_i[sbp_pkg::CAP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values beyond what the storage holds saturate to the built-in limits.
  always_comb begin
    if (32'(active_parts_q) > NUM_PARTS) begin
      parts_eff = PW'(NUM_PARTS);
    end else begin
      parts_eff = PW'(active_parts_q);
    end
    if (32'(bucket_capacity_q) > MAX_CAPACITY) begin
      cap_eff = CAPW'(MAX_CAPACITY);
    end else begin
      cap_eff = CAPW'(bucket_capacity_q);
    end
  end

  sbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .kind_i    (s_axis_tuser[sbp_pkg::KIND_W-1:0]),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sbp_datapath #(
    .NUM_PARTS    (NUM_PARTS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .parts_i   (parts_eff),
    .cap_i     (cap_eff),
    .sidx_i    (s_axis_tdata[sbp_pkg::SIDX_W-1:0]),
    .value_i   (s_axis_tdata[sbp_pkg::SIDX_W +: sbp_pkg::VALUE_W]),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .bucket_o  (res_bucket),
    .slot_o    (res_slot),
    .addr_o    (res_addr),
    .value_o   (res_value),
    .beyond_o  (res_beyond),
    .full_o    (res_full)
  );

  assign m_axis_tdata = {3'b000, res_value, res_addr, res_slot, res_bucket};
  assign m_axis_tuser = {res_full, res_beyond};

endmodule

[verif/testbench.sv]
// Self-checking testbench for the splitter bucket partitioner: directed rows, then random phases.
module testbench;
  import sbp_pkg::*;

  localparam int PARTS_MAX     = 64;
  localparam int CAP_MAX       = 65536;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1600;

  localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   addr;
    logic [VALUE_W-1:0]  value;
    logic                beyond;
    logic                full;
  } placement_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_e;

  typedef struct {
    row_e                 what;
    logic [KIND_W-1:0]    kind;
    logic [SIDX_W-1:0]    sidx;
    logic signed [63:0]   val;
    bit                   typed;
    placement_t           want;
    sbp_cfg_idx_e         cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state.
  logic signed [63:0]   splitters [PARTS_MAX];
  int                   fill_counts [PARTS_MAX];
  logic [PARTS_CFG_W-1:0] parts_cfg;
  logic [CAP_CFG_W-1:0]   cap_cfg;

  placement_t placements_due [$];
  placement_t head;
  plan_row_t  plan [$];

  int  fail_count    = 0;
  int  results_seen  = 0;
  int  cycle_count   = 0;
  int  tx_calm       = 0;
  int  rx_calm       = 0;
  bit  hold_request  = 0;
  bit  hold_done     = 0;

  logic [PARTS_CFG_W-1:0] parts_edges [7] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd63};
  logic [CAP_CFG_W-1:0]   cap_edges [7] =
    '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd2, 17'd65537, 17'd3};

  splitter_bucket_partitioner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_failure(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic logic signed [63:0] seed_splitter(input int i);
    return longint'(i - 32) * (longint'(1) << 58) + (longint'(1) << 57);
  endfunction

  // Applies one accepted transaction to the predictor; returns 1 when it yields a placement.
  function automatic bit partition_step(input logic [KIND_W-1:0] kind,
                                        input logic [SIDX_W-1:0] sidx,
                                        input logic signed [63:0] val,
                                        output placement_t p);
    int                lo, hi, mid, found, parts;
    longint            cap, addr_full;
    logic [SIDX_W-1:0] bi;
    p = '0;
    if (kind == KIND_LOAD) begin
      splitters[sidx] = val;
      return 0;
    end
    if (kind == KIND_CLEAR) begin
      foreach (fill_counts[i]) fill_counts[i] = 0;
      return 0;
    end
    if (kind != KIND_CLASSIFY) return 0;
    parts = (parts_cfg > PARTS_MAX) ? PARTS_MAX : int'(parts_cfg);
    cap = (cap_cfg > CAP_MAX) ? CAP_MAX : longint'(cap_cfg);
    lo = 0;
    hi = parts - 1;
    found = parts;
    // Same probe order as the hardware search, so unordered tables match too.
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (splitters[mid[SIDX_W-1:0]] > val) begin
        found = mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    bi = found[SIDX_W-1:0];
    p.bucket = found[BUCKET_W-1:0];
    p.value = val;
    if (found >= parts) begin
      p.beyond = 1'b1;
    end else if (fill_counts[bi] >= cap) begin
      p.full = 1'b1;
    end else begin
      addr_full = longint'(found) * cap + fill_counts[bi];
      p.slot = fill_counts[bi][SLOT_W-1:0];
      p.addr = addr_full[ADDR_W-1:0];
      fill_counts[bi]++;
    end
    return 1;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [63:0] pick_element();
    int pe, k, r;
    pe = (parts_cfg > PARTS_MAX) ? PARTS_MAX : int'(parts_cfg);
    k = (pe == 0) ? $urandom_range(0, PARTS_MAX - 1) : $urandom_range(0, pe - 1);
    r = $urandom_range(0, 9);
    // Values right around a splitter exercise the strict greater-than.
    if (r < 5) return splitters[k[SIDX_W-1:0]] + longint'(int'($urandom_range(0, 4)) - 2);
    if (r < 8) return {$urandom, $urandom};
    if (r == 8) return VAL_MIN;
    return VAL_MAX;
  endfunction

  function automatic plan_row_t item_row(input logic [KIND_W-1:0] kind,
                                         input logic [SIDX_W-1:0] sidx,
                                         input logic signed [63:0] val);
    plan_row_t row;
    row = '{what: ROW_ITEM, kind: kind, sidx: sidx, val: val, typed: 1'b0, want: '0,
            cfg_idx: CFG_ACTIVE_PARTS, cfg_data: '0};
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic signed [63:0] val,
                                            input logic [BUCKET_W-1:0] bucket,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic beyond, input logic full);
    plan_row_t row;
    row = item_row(KIND_CLASSIFY, '0, val);
    row.typed = 1'b1;
    row.want = '{bucket: bucket, slot: slot, addr: addr, value: val, beyond: beyond,
                 full: full};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input sbp_cfg_idx_e idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = item_row(KIND_UNUSED, '0, '0);
    row.what = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_data = data;
    return row;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SIDX_W-1:0] sidx,
                           input logic signed [63:0] val, input bit typed = 1'b0,
                           input placement_t want = '0);
    placement_t p;
    bit         has;
    int         gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, sidx};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    has = partition_step(kind, sidx, val, p);
    if (has) placements_due.push_back(typed ? want : p);
    @(negedge clk_i);
  endtask

  // Registers change only with the block idle; loads and clears leave no result to wait on,
  // so a settling wait afterwards covers any transaction still in the search.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input sbp_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ACTIVE_PARTS) parts_cfg = data[PARTS_CFG_W-1:0];
    else cap_cfg = data[CAP_CFG_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_ascending_table();
    logic signed [63:0] v;
    logic [63:0]        r;
    int                 s;
    s = $urandom_range(0, 55);
    r = {$urandom, $urandom};
    v = {2'b11, r[61:0]};
    for (int i = 0; i < PARTS_MAX; i++) begin
      send_item(KIND_LOAD, i[SIDX_W-1:0], v);
      v = v + $signed({$urandom, $urandom} >> (63 - s));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (placements_due.size() == 0) begin
        report_failure($sformatf("result %0d arrived with no element pending", results_seen));
      end else begin
        head = placements_due.pop_front();
        if (m_axis_tdata[6:0] !== head.bucket)
          report_failure($sformatf("result %0d bucket_index %0d, expected %0d",
                                   results_seen, m_axis_tdata[6:0], head.bucket));
        if (m_axis_tdata[22:7] !== head.slot)
          report_failure($sformatf("result %0d slot %0d, expected %0d",
                                   results_seen, m_axis_tdata[22:7], head.slot));
        if (m_axis_tdata[44:23] !== head.addr)
          report_failure($sformatf("result %0d buffer_address %0d, expected %0d",
                                   results_seen, m_axis_tdata[44:23], head.addr));
        if (m_axis_tdata[108:45] !== head.value)
          report_failure($sformatf("result %0d element_value_res %h, expected %h",
                                   results_seen, m_axis_tdata[108:45], head.value));
        if (m_axis_tuser[0] !== head.beyond)
          report_failure($sformatf("result %0d beyond_all %b, expected %b",
                                   results_seen, m_axis_tuser[0], head.beyond));
        if (m_axis_tuser[1] !== head.full)
          report_failure($sformatf("result %0d bucket_full %b, expected %b",
                                   results_seen, m_axis_tuser[1], head.full));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = pick_gap(rx_calm);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    int                    phase, counted, burst, r, drain;
    logic [PARTS_CFG_W-1:0] pv;
    logic [CAP_CFG_W-1:0]   cv;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ACTIVE_PARTS;
    cfg_data_i    = '0;
    parts_cfg     = PARTS_RESET;
    cap_cfg       = CAP_RESET;
    foreach (fill_counts[i]) fill_counts[i] = 0;
    foreach (splitters[i]) splitters[i] = '0;

    plan.push_back(checked_row(VAL_MIN, 7'd0, 16'd0, 22'd0, 1'b0, 1'b0));
    plan.push_back(checked_row(VAL_MAX, 7'd64, 16'd0, 22'd0, 1'b1, 1'b0));
    plan.push_back(checked_row(seed_splitter(63) - 1, 7'd63, 16'd0, 22'd4128768, 1'b0, 1'b0));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd0, seed_splitter(0)));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd0, seed_splitter(0) - 1));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd63, 64'sd0));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd21, -64'sd1));
    plan.push_back(item_row(KIND_UNUSED, 6'd42, VAL_MIN));
    // Break the ordering at one entry so the search takes a wrong turn.
    plan.push_back(item_row(KIND_LOAD, 6'd5, VAL_MIN));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd0, seed_splitter(4) + 1));
    plan.push_back(item_row(KIND_LOAD, 6'd5, seed_splitter(5)));
    plan.push_back(item_row(KIND_CLEAR, 6'd0, 64'sd0));
    plan.push_back(checked_row(VAL_MIN, 7'd0, 16'd0, 22'd0, 1'b0, 1'b0));
    plan.push_back(cfg_row(CFG_ACTIVE_PARTS, 17'd0));
    plan.push_back(checked_row(64'sd0, 7'd0, 16'd0, 22'd0, 1'b1, 1'b0));
    plan.push_back(cfg_row(CFG_ACTIVE_PARTS, 17'd127));
    plan.push_back(checked_row(VAL_MAX, 7'd64, 16'd0, 22'd0, 1'b1, 1'b0));
    plan.push_back(cfg_row(CFG_BUCKET_CAPACITY, 17'd0));
    plan.push_back(checked_row(VAL_MIN, 7'd0, 16'd0, 22'd0, 1'b0, 1'b1));
    plan.push_back(cfg_row(CFG_BUCKET_CAPACITY, 17'd131071));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd10, seed_splitter(10)));
    plan.push_back(cfg_row(CFG_BUCKET_CAPACITY, 17'd1));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd0, VAL_MIN));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd20, seed_splitter(20)));
    plan.push_back(item_row(KIND_CLASSIFY, 6'd20, seed_splitter(20)));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every entry is written before the first search can read it.
    for (int i = 0; i < PARTS_MAX; i++) send_item(KIND_LOAD, i[SIDX_W-1:0], seed_splitter(i));

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].what == ROW_CFG) begin
        wait_idle();
        write_cfg(plan[i].cfg_idx, plan[i].cfg_data);
      end else begin
        send_item(plan[i].kind, plan[i].sidx, plan[i].val, plan[i].typed, plan[i].want);
      end
    end

    phase = 0;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      wait_idle();
      if (phase < 7 || $urandom_range(0, 1) == 0) begin
        if (phase < 7) pv = parts_edges[phase[2:0]];
        else if ($urandom_range(0, 7) == 0) pv = PARTS_CFG_W'($urandom_range(65, 127));
        else if ($urandom_range(0, 2) == 0) pv = PARTS_CFG_W'($urandom_range(1, 4));
        else pv = PARTS_CFG_W'($urandom_range(1, PARTS_MAX));
        // Bits above the register width are don't-care on an active_parts write.
        write_cfg(CFG_ACTIVE_PARTS, {($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0, pv});
      end
      if (phase < 7 || $urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 9);
        if (phase < 7) cv = cap_edges[phase[2:0]];
        else if (r < 5) cv = CAP_CFG_W'($urandom_range(1, 8));
        else if (r < 8) cv = CAP_CFG_W'($urandom_range(1, CAP_MAX));
        else if (r < 9) cv = CAP_CFG_W'($urandom_range(CAP_MAX + 1, 131071));
        else cv = '0;
        write_cfg(CFG_BUCKET_CAPACITY, cv);
      end
      if (phase % 4 == 1 || $urandom_range(0, 5) == 0) begin
        load_ascending_table();
        counted += PARTS_MAX;
      end
      if ($urandom_range(0, 1) == 0) begin
        send_item(KIND_CLEAR, 6'($urandom), {$urandom, $urandom});
        counted++;
      end
      if (phase == 3) hold_request = 1'b1;
      burst = (phase == 3) ? 120 : $urandom_range(20, 80);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_item(KIND_CLASSIFY, 6'($urandom), pick_element());
          counted++;
        end else if (r < 88) begin
          send_item(KIND_LOAD, 6'($urandom), {$urandom, $urandom});
          counted++;
        end else if (r < 93) begin
          send_item(KIND_CLEAR, 6'($urandom), {$urandom, $urandom});
          counted++;
        end else begin
          send_item(KIND_UNUSED, 6'($urandom), {$urandom, $urandom});
        end
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (placements_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    if (placements_due.size() != 0)
      report_failure($sformatf("%0d expected results never arrived", placements_due.size()));
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sbp_pkg.sv
hw/rtl/sbp_ctrl.sv
hw/rtl/sbp_datapath.sv
hw/rtl/splitter_bucket_partitioner.sv
verif/testbench.sv
